/* src/awmf_pkg.sv */
// Shared types, widths and codes of the adaptive window median filter.
// No dependencies; the design files refer to it by scoped names, the testbench imports it.
package awmf_pkg;

	localparam int STORE_DEPTH = 16;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int LEN_W       = $clog2(STORE_DEPTH + 1);

	localparam int RAW_W       = 24;
	localparam int VAL_W       = 25;
	localparam int DIFF_W      = 26;
	localparam int TEN_W       = 29;
	localparam int CFG_WIN_W   = 5;
	localparam int STEP_W      = 4;
	localparam int CMP_W       = ((LEN_W > CFG_WIN_W) ? LEN_W : CFG_WIN_W) + 1;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_IDX_W-1:0] REG_TARE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_INC = 3'd3;

	localparam logic [CFG_WIN_W-1:0] MIN_WIN_RESET  = 5'd3;
	localparam logic [CFG_WIN_W-1:0] MAX_WIN_RESET  = 5'd16;
	localparam logic [STEP_W-1:0]    STEP_INC_RESET = 4'd2;
	localparam int                   WIN_RESET      = (STORE_DEPTH < 3) ? STORE_DEPTH : 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_ABS,
		ST_TEST,
		ST_WIN,
		ST_WRITE,
		ST_SORT,
		ST_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		SEL_IDLE,
		SEL_CAND,
		SEL_SCAN,
		SEL_EVAL
	} sel_state_t;

	typedef struct packed {
		logic             start;
		logic [LEN_W-1:0] len;
	} sel_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [VAL_W-1:0] median;
	} sel_rsp_t;

endpackage

/* src/awmf_if.sv */
// Handshake channels of the adaptive window median filter: samples,
// results and configuration writes. Widths come from awmf_pkg.
interface awmf_sample_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [awmf_pkg::RAW_W-1:0]       raw_sample;

	modport source (output valid, output raw_sample, input ready);
	modport sink   (input valid, input raw_sample, output ready);
endinterface

interface awmf_result_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [awmf_pkg::VAL_W-1:0]       filtered_value;
	logic        [awmf_pkg::LEN_W-1:0]       window_len;

	modport source (output valid, output filtered_value, output window_len, input ready);
	modport sink   (input valid, input filtered_value, input window_len, output ready);
endinterface

interface awmf_cfg_if;
	logic                                    valid;
	logic                                    ready;
	logic        [awmf_pkg::CFG_IDX_W-1:0]   index;
	logic        [awmf_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/awmf_store.sv */
// Sample ring store: one write port, one registered read port.
// Entries never written read as zero. Depends on awmf_pkg.
module awmf_store (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic        [awmf_pkg::IDX_W-1:0]    wr_addr,
	input  logic signed [awmf_pkg::VAL_W-1:0]    wr_data,
	input  logic        [awmf_pkg::IDX_W-1:0]    rd_addr,
	output logic signed [awmf_pkg::VAL_W-1:0]    rd_data
);

	logic signed [awmf_pkg::VAL_W-1:0] mem_q [awmf_pkg::STORE_DEPTH];
	logic        [awmf_pkg::STORE_DEPTH-1:0] written_q;
	logic signed [awmf_pkg::VAL_W-1:0] rd_data_q;
	logic                              rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			rd_written_q <= written_q[rd_addr];
		end
	end

	assign rd_data = rd_written_q ? rd_data_q : '0;

endmodule

/* src/awmf_select.sv */
// Rank selection over the store with one shared comparator: each candidate
// is compared against every entry of the window. Depends on awmf_pkg.
module awmf_select (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  awmf_pkg::sel_req_t                   req,
	output awmf_pkg::sel_rsp_t                   rsp,
	output logic        [awmf_pkg::IDX_W-1:0]    rd_addr,
	input  logic signed [awmf_pkg::VAL_W-1:0]    rd_data
);

	awmf_pkg::sel_state_t state_q, state_d;

	logic        [awmf_pkg::LEN_W-1:0] len_q;
	logic        [awmf_pkg::LEN_W-1:0] rank_q;
	logic        [awmf_pkg::IDX_W-1:0] cand_idx_q;
	logic        [awmf_pkg::IDX_W-1:0] scan_idx_q;
	logic        [awmf_pkg::LEN_W-1:0] lt_cnt_q;
	logic        [awmf_pkg::LEN_W-1:0] le_cnt_q;
	logic signed [awmf_pkg::VAL_W-1:0] cand_q;

	logic is_lt;
	logic is_le;
	logic last_scan;
	logic found;

	// The one comparator, shared over every candidate and entry
	assign is_lt     = rd_data < cand_q;
	assign is_le     = rd_data <= cand_q;
	assign last_scan = awmf_pkg::LEN_W'(scan_idx_q) == (len_q - 1'b1);
	assign found     = (lt_cnt_q <= rank_q) && (le_cnt_q > rank_q);

	always_comb begin
		state_d    = state_q;
		rd_addr    = '0;
		rsp.done   = 1'b0;
		rsp.median = cand_q;
		unique case (state_q)
			awmf_pkg::SEL_IDLE: begin
				rd_addr = '0;
				if (req.start) begin
					state_d = awmf_pkg::SEL_CAND;
				end
			end
			awmf_pkg::SEL_CAND: begin
				rd_addr = '0;
				state_d = awmf_pkg::SEL_SCAN;
			end
			awmf_pkg::SEL_SCAN: begin
				rd_addr = scan_idx_q + 1'b1;
				if (last_scan) begin
					state_d = awmf_pkg::SEL_EVAL;
				end
			end
			awmf_pkg::SEL_EVAL: begin
				rd_addr = cand_idx_q + 1'b1;
				if (found) begin
					rsp.done = 1'b1;
					state_d  = awmf_pkg::SEL_IDLE;
				end else begin
					state_d  = awmf_pkg::SEL_CAND;
				end
			end
			default: begin
				state_d = awmf_pkg::SEL_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= awmf_pkg::SEL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			awmf_pkg::SEL_IDLE: begin
				len_q      <= req.len;
				rank_q     <= req.len >> 1;
				cand_idx_q <= '0;
			end
			awmf_pkg::SEL_CAND: begin
				cand_q     <= rd_data;
				scan_idx_q <= '0;
				lt_cnt_q   <= '0;
				le_cnt_q   <= '0;
			end
			awmf_pkg::SEL_SCAN: begin
				lt_cnt_q   <= lt_cnt_q + awmf_pkg::LEN_W'(is_lt);
				le_cnt_q   <= le_cnt_q + awmf_pkg::LEN_W'(is_le);
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			awmf_pkg::SEL_EVAL: begin
				cand_idx_q <= cand_idx_q + 1'b1;
			end
			default: begin
				cand_idx_q <= cand_idx_q;
			end
		endcase
	end

endmodule

/* src/adaptive_window_median_filter_top.sv */
// Top level of the adaptive window median filter: sequencer, step test,
// window control and output register. Depends on awmf_pkg, awmf_if,
// awmf_store and awmf_select.
//
//  Channel   Direction  Beat content
//  -------   ---------  -------------------------------------------------
//  cfg       in         register index (0 tare, 1 min, 2 max, 3 step), data
//  samples   in         raw_sample, 24-bit signed
//  results   out        filtered_value (25-bit signed), window_len
//
// From acceptance a sample passes through the states DIFF, ABS, TEST, WIN
// and WRITE, then SORT once the store has filled, and then OUT. In SORT
// the single comparator of the rank selector, fed by the store's one read
// port, checks each candidate against every entry of the window in turn.
// samples.ready is high only while the sequencer idles. A result waits in
// the output register while results.ready is low; the next sample may be
// taken meanwhile, and only its hand-over waits.
// Reset clears the store (through per-entry written flags), the ring slot,
// the fill flag, the last output, and sets the window length to three.
module adaptive_window_median_filter_top (
	input  logic          clk,
	input  logic          arst_n,
	awmf_cfg_if.sink      cfg,
	awmf_sample_if.sink   samples,
	awmf_result_if.source results
);

	// Configuration registers
	logic signed [awmf_pkg::RAW_W-1:0]     tare_q;
	logic        [awmf_pkg::CFG_WIN_W-1:0] min_win_q;
	logic        [awmf_pkg::CFG_WIN_W-1:0] max_win_q;
	logic        [awmf_pkg::STEP_W-1:0]    step_inc_q;

	// Sequencer and filter state
	awmf_pkg::ctrl_state_t state_q, state_d;

	logic signed [awmf_pkg::VAL_W-1:0]  x_q;
	logic signed [awmf_pkg::VAL_W-1:0]  last_q;
	logic signed [awmf_pkg::DIFF_W-1:0] diff_q;
	logic        [awmf_pkg::VAL_W-1:0]  mag_q;
	logic                               step_q;
	logic        [awmf_pkg::LEN_W-1:0]  win_q;
	logic        [awmf_pkg::IDX_W-1:0]  slot_q;
	logic                               full_q;
	logic signed [awmf_pkg::VAL_W-1:0]  med_q;

	// Output register
	logic                               out_valid_q;
	logic signed [awmf_pkg::VAL_W-1:0]  out_val_q;
	logic        [awmf_pkg::LEN_W-1:0]  out_len_q;

	// Datapath helpers
	logic        [awmf_pkg::TEN_W-1:0]  ten_mag;
	logic                               step_hit;
	logic        [awmf_pkg::CMP_W-1:0]  max_ext;
	logic        [awmf_pkg::CMP_W-1:0]  min_ext;
	logic        [awmf_pkg::CMP_W-1:0]  hi_w;
	logic        [awmf_pkg::CMP_W-1:0]  lo_w;
	logic        [awmf_pkg::CMP_W-1:0]  win_up;
	logic        [awmf_pkg::CMP_W-1:0]  win_dn;
	logic        [awmf_pkg::CMP_W-1:0]  win_next;
	logic        [awmf_pkg::LEN_W-1:0]  slot_inc;
	logic                               wrap;
	logic                               full_next;
	logic                               out_free;

	// Store and selector hookup
	logic                               st_wr_en;
	logic        [awmf_pkg::IDX_W-1:0]  st_rd_addr;
	logic signed [awmf_pkg::VAL_W-1:0]  st_rd_data;
	awmf_pkg::sel_req_t                 sel_req;
	awmf_pkg::sel_rsp_t                 sel_rsp;

	awmf_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (st_wr_en),
		.wr_addr (slot_q),
		.wr_data (x_q),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data)
	);

	awmf_select u_select (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (sel_req),
		.rsp     (sel_rsp),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data)
	);

	// Configuration writes are always taken; unknown indexes drop silently
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_q     <= '0;
			min_win_q  <= awmf_pkg::MIN_WIN_RESET;
			max_win_q  <= awmf_pkg::MAX_WIN_RESET;
			step_inc_q <= awmf_pkg::STEP_INC_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				awmf_pkg::REG_TARE:     tare_q     <= cfg.data;
				awmf_pkg::REG_MIN_WIN:  min_win_q  <= cfg.data[awmf_pkg::CFG_WIN_W-1:0];
				awmf_pkg::REG_MAX_WIN:  max_win_q  <= cfg.data[awmf_pkg::CFG_WIN_W-1:0];
				awmf_pkg::REG_STEP_INC: step_inc_q <= cfg.data[awmf_pkg::STEP_W-1:0];
				default: begin
					tare_q <= tare_q;
				end
			endcase
		end
	end

	// Step test: ten times the change against the last output. A negative
	// last output always counts as a step.
	assign ten_mag  = awmf_pkg::TEN_W'({mag_q, 3'b000}) +
		awmf_pkg::TEN_W'({mag_q, 1'b0});
	assign step_hit = last_q[awmf_pkg::VAL_W-1] ||
		(ten_mag > awmf_pkg::TEN_W'(last_q[awmf_pkg::VAL_W-2:0]));

	// Window bounds: zero reads as one, maximum clamped to the store depth, minimum to the maximum
	assign max_ext = awmf_pkg::CMP_W'(max_win_q);
	assign min_ext = awmf_pkg::CMP_W'(min_win_q);

	always_comb begin
		if (max_ext == '0) begin
			hi_w = awmf_pkg::CMP_W'(1);
		end else if (max_ext > awmf_pkg::CMP_W'(awmf_pkg::STORE_DEPTH)) begin
			hi_w = awmf_pkg::CMP_W'(awmf_pkg::STORE_DEPTH);
		end else begin
			hi_w = max_ext;
		end
		if (min_ext == '0) begin
			lo_w = awmf_pkg::CMP_W'(1);
		end else if (min_ext > hi_w) begin
			lo_w = hi_w;
		end else begin
			lo_w = min_ext;
		end
	end

	assign win_up   = awmf_pkg::CMP_W'(win_q) + awmf_pkg::CMP_W'(step_inc_q);
	assign win_dn   = awmf_pkg::CMP_W'(win_q) - 1'b1;
	assign win_next = step_q ? ((win_up < hi_w) ? win_up : hi_w)
	                         : ((win_dn > lo_w) ? win_dn : lo_w);

	// Ring slot advance against the window just chosen
	assign slot_inc  = awmf_pkg::LEN_W'(slot_q) + 1'b1;
	assign wrap      = slot_inc >= win_q;
	assign full_next = full_q || wrap;

	assign out_free  = !out_valid_q || results.ready;

	// Sequencer: next state and strobes
	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		st_wr_en      = 1'b0;
		sel_req.start = 1'b0;
		sel_req.len   = win_q;
		unique case (state_q)
			awmf_pkg::ST_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					state_d = awmf_pkg::ST_DIFF;
				end
			end
			awmf_pkg::ST_DIFF:  state_d = awmf_pkg::ST_ABS;
			awmf_pkg::ST_ABS:   state_d = awmf_pkg::ST_TEST;
			awmf_pkg::ST_TEST:  state_d = awmf_pkg::ST_WIN;
			awmf_pkg::ST_WIN:   state_d = awmf_pkg::ST_WRITE;
			awmf_pkg::ST_WRITE: begin
				st_wr_en = 1'b1;
				if (full_next) begin
					state_d = awmf_pkg::ST_SORT;
				end else begin
					state_d = awmf_pkg::ST_OUT;
				end
			end
			awmf_pkg::ST_SORT: begin
				// Hold start through the sort; the selector only looks at it
				// while idle, as it is in the cycle after the new sample is written
				sel_req.start = 1'b1;
				if (sel_rsp.done) begin
					state_d = awmf_pkg::ST_OUT;
				end
			end
			awmf_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = awmf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = awmf_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= awmf_pkg::ST_IDLE;
			win_q       <= awmf_pkg::LEN_W'(awmf_pkg::WIN_RESET);
			slot_q      <= '0;
			full_q      <= 1'b0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == awmf_pkg::ST_WIN) begin
				win_q <= awmf_pkg::LEN_W'(win_next);
			end
			if (state_q == awmf_pkg::ST_WRITE) begin
				slot_q <= wrap ? '0 : awmf_pkg::IDX_W'(slot_inc);
				full_q <= full_next;
			end
			if (state_q == awmf_pkg::ST_OUT && out_free) begin
				last_q      <= med_q;
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: take the beat, difference, magnitude, step flag, result
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			x_q <= awmf_pkg::VAL_W'(samples.raw_sample) - awmf_pkg::VAL_W'(tare_q);
		end
		if (state_q == awmf_pkg::ST_DIFF) begin
			diff_q <= awmf_pkg::DIFF_W'(x_q) - awmf_pkg::DIFF_W'(last_q);
		end
		if (state_q == awmf_pkg::ST_ABS) begin
			mag_q <= diff_q[awmf_pkg::DIFF_W-1] ? awmf_pkg::VAL_W'(-diff_q)
			                                    : awmf_pkg::VAL_W'(diff_q);
		end
		if (state_q == awmf_pkg::ST_TEST) begin
			step_q <= step_hit;
		end
		if (state_q == awmf_pkg::ST_WRITE && !full_next) begin
			med_q <= x_q;
		end else if (state_q == awmf_pkg::ST_SORT && sel_rsp.done) begin
			med_q <= sel_rsp.median;
		end
		if (state_q == awmf_pkg::ST_OUT && out_free) begin
			out_val_q <= med_q;
			out_len_q <= win_q;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.filtered_value = out_val_q;
	assign results.window_len     = out_len_q;

endmodule

/* dv/tb_adaptive_window_median_filter_top.sv */
// Self-checking testbench of the adaptive window median filter top level.
// Needs awmf_pkg, the channel interfaces of awmf_if and the RTL under src.
// Clocked driver and monitor around dut, with an in-bench prediction of each beat.
module tb_adaptive_window_median_filter_top;
	timeunit 1ns;
	timeprecision 1ps;

	import awmf_pkg::*;

	localparam int CLK_PERIOD     = 2;
	localparam int RESET_CYCLES   = 7;
	localparam int IDLE_PCT       = 19;
	// No idling on either side once this many beats have gone through, up to QUIET_TO.
	localparam int QUIET_FROM     = 600;
	localparam int QUIET_TO       = 900;
	// The sender stops after every DRAIN_EVERY samples until all results are back.
	localparam int DRAIN_EVERY    = 250;
	// Allow a wide margin over the worst-case wait for one sample's result.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 300;
	localparam int PRINT_CAP      = 40;
	localparam int NUM_REGS       = 4;
	localparam int PHASE_ITEMS    = 190;
	localparam int NUM_PHASES     = 8;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [LEN_W-1:0]        size;
	} filtered_t;

	logic clk = 1'b0;
	logic arst_n;

	awmf_cfg_if    cfg_ch ();
	awmf_sample_if sample_ch ();
	awmf_result_if result_ch ();

	adaptive_window_median_filter_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch.sink),
		.samples (sample_ch.sink),
		.results (result_ch.source)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Register copies as the block should hold them.
	logic signed [RAW_W-1:0]   tare_q;
	logic [CFG_WIN_W-1:0]      min_win_q;
	logic [CFG_WIN_W-1:0]      max_win_q;
	logic [STEP_W-1:0]         step_inc_q;

	// Filter state as the block should hold it.
	logic signed [VAL_W-1:0]   held_samples [STORE_DEPTH];
	logic [LEN_W-1:0]          ring_slot;
	logic                      ring_filled;
	logic [LEN_W-1:0]          win_len;
	logic signed [VAL_W-1:0]   last_filtered;

	logic signed [RAW_W-1:0]   raw_backlog [$];
	filtered_t                 awaited_filtered [$];

	int  total_loaded  = 0;
	int  beats_in      = 0;
	int  results_done  = 0;
	int  cfg_writes    = 0;
	int  mismatch_count = 0;
	int  quiet_cycles  = 0;
	bit  sender_drain  = 1'b0;
	bit  sample_fire;
	bit  sender_idle;
	bit  [31:0] windows_seen = '0;
	filtered_t want;

	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_CAP)
			$display("MISMATCH at %0t ns: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic void clear_filter_state();
		foreach (held_samples[i])
			held_samples[i] = '0;
		ring_slot     = '0;
		ring_filled   = 1'b0;
		win_len       = LEN_W'(WIN_RESET);
		last_filtered = '0;
		tare_q        = '0;
		min_win_q     = MIN_WIN_RESET;
		max_win_q     = MAX_WIN_RESET;
		step_inc_q    = STEP_INC_RESET;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
	                                       input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_TARE:     tare_q     = data[RAW_W-1:0];
			REG_MIN_WIN:  min_win_q  = data[CFG_WIN_W-1:0];
			REG_MAX_WIN:  max_win_q  = data[CFG_WIN_W-1:0];
			REG_STEP_INC: step_inc_q = data[STEP_W-1:0];
			default: ;
		endcase
	endfunction

	// Advance the filter state by one sample and return the beat it must produce.
	function automatic filtered_t next_filtered(input logic signed [RAW_W-1:0] raw);
		logic signed [VAL_W-1:0] x;
		longint                  gap;
		int                      hi, lo, n, len, j, v;
		int                      ordered [STORE_DEPTH];
		filtered_t               r;
		x   = {raw[RAW_W-1], raw} - {tare_q[RAW_W-1], tare_q};
		gap = longint'(x) - longint'(last_filtered);
		if (gap < 0)
			gap = -gap;
		// Clamp the maximum to the store, then the minimum under the maximum.
		hi = int'(max_win_q);
		if (hi < 1)
			hi = 1;
		if (hi > STORE_DEPTH)
			hi = STORE_DEPTH;
		lo = int'(min_win_q);
		if (lo < 1)
			lo = 1;
		if (lo > hi)
			lo = hi;
		// A negative last output makes the relative step test always true.
		if (gap * 10 > longint'(last_filtered)) begin
			n   = int'(win_len) + int'(step_inc_q);
			len = (n < hi) ? n : hi;
		end else begin
			n   = int'(win_len) - 1;
			len = (n > lo) ? n : lo;
		end
		if (len < 1)
			len = 1;
		if (len > STORE_DEPTH)
			len = STORE_DEPTH;
		win_len = LEN_W'(len);
		// The slot may sit beyond a shrunk window; write there and then wrap.
		if (int'(ring_slot) >= STORE_DEPTH)
			ring_slot = '0;
		held_samples[ring_slot[IDX_W-1:0]] = x;
		ring_slot = ring_slot + 1'b1;
		if (int'(ring_slot) >= len) begin
			ring_slot   = '0;
			ring_filled = 1'b1;
		end
		if (!ring_filled) begin
			r.value = x;
		end else begin
			// Stale entries from earlier windows take part, as they stand.
			for (int i = 0; i < len; i++)
				ordered[i] = int'(held_samples[i]);
			for (int i = 1; i < len; i++) begin
				v = ordered[i];
				j = i;
				while (j > 0 && ordered[j-1] > v) begin
					ordered[j] = ordered[j-1];
					j--;
				end
				ordered[j] = v;
			end
			r.value = VAL_W'(ordered[len / 2]);
		end
		r.size        = LEN_W'(len);
		last_filtered = r.value;
		return r;
	endfunction

	// Sample driver: hold a presented beat until taken, otherwise offer the next
	// pending sample unless idling or draining.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid      <= 1'b0;
			sample_ch.raw_sample <= '0;
		end else begin
			sample_fire = sample_ch.valid && sample_ch.ready;
			if (sample_fire) begin
				awaited_filtered.push_back(next_filtered(raw_backlog.pop_front()));
				beats_in++;
				if (beats_in % DRAIN_EVERY == 0)
					sender_drain = 1'b1;
			end
			// Release the drain once every result of the samples taken is back.
			if (sender_drain && results_done == beats_in)
				sender_drain = 1'b0;
			sender_idle = ($urandom_range(0, 99) < IDLE_PCT)
				&& !(beats_in >= QUIET_FROM && beats_in < QUIET_TO);
			if (sample_ch.valid && !sample_fire) begin
				// Hold the beat on offer.
			end else if (raw_backlog.size() != 0 && !sender_drain && !sender_idle) begin
				sample_ch.valid      <= 1'b1;
				sample_ch.raw_sample <= raw_backlog[0];
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor: compare each beat taken with the oldest prediction, then
	// pick a fresh ready for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (awaited_filtered.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing awaited: value %0d size %0d",
						results_done, result_ch.filtered_value, result_ch.window_len));
				end else begin
					want = awaited_filtered.pop_front();
					if (result_ch.filtered_value !== want.value)
						report_mismatch($sformatf("result %0d filtered_value %0d, predicted %0d",
							results_done, result_ch.filtered_value, want.value));
					if (result_ch.window_len !== want.size)
						report_mismatch($sformatf("result %0d window_len %0d, predicted %0d",
							results_done, result_ch.window_len, want.size));
				end
				windows_seen[result_ch.window_len] = 1'b1;
				results_done <= results_done + 1;
			end
			result_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT)
				|| (results_done >= QUIET_FROM && results_done < QUIET_TO);
		end
	end

	// Watchdog: end the run if nothing moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no beat for %0d cycles, %0d of %0d results back",
					quiet_cycles, results_done, total_loaded);
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		apply_register(idx, data);
		cfg_writes++;
		cfg_ch.valid <= 1'b0;
	endtask

	// Write all four registers, with junk in the unused data bits, plus one
	// write to an unmapped index that must be dropped.
	task automatic write_settings(input logic [RAW_W-1:0] tare, input logic [CFG_WIN_W-1:0] lo,
	                              input logic [CFG_WIN_W-1:0] hi, input logic [STEP_W-1:0] inc);
		cfg_write(REG_TARE, tare);
		cfg_write(REG_MIN_WIN, {19'($urandom), lo});
		cfg_write(REG_MAX_WIN, {19'($urandom), hi});
		cfg_write(REG_STEP_INC, {20'($urandom), inc});
		cfg_write(CFG_IDX_W'(NUM_REGS + $urandom_range(0, 3)), CFG_DATA_W'($urandom));
	endtask

	// Wait until every sample handed over has come back as a result.
	task automatic wait_drained();
		while (results_done != total_loaded)
			@(posedge clk);
	endtask

	task automatic push_raw(input logic [RAW_W-1:0] v);
		raw_backlog.push_back(v);
		total_loaded++;
	endtask

	// Mostly plateaus with a little noise, so windows shrink and then jump
	// on the next step; the rest is full-range noise and extreme codes.
	task automatic queue_stream(input int count);
		int     made, kind, run, level, spread;
		longint raw;
		made = 0;
		while (made < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				case ($urandom_range(0, 2))
					0:       level = $urandom_range(0, 100);
					1:       level = $urandom_range(101, 65535);
					default: level = $urandom_range(65536, 8000000);
				endcase
				if ($urandom_range(0, 4) == 0)
					level = -level;
				spread = ((level < 0) ? -level : level) / 40;
				run    = $urandom_range(1, 30);
				for (int k = 0; k < run && made < count; k++) begin
					raw = longint'(level) + longint'($urandom_range(0, 2 * spread))
						- longint'(spread) + longint'(tare_q);
					if (raw > 64'sd8388607)
						raw = 64'sd8388607;
					if (raw < -64'sd8388608)
						raw = -64'sd8388608;
					push_raw(raw[RAW_W-1:0]);
					made++;
				end
			end else if (kind < 85) begin
				push_raw(RAW_W'($urandom));
				made++;
			end else begin
				case ($urandom_range(0, 4))
					0:       push_raw(24'h7FFFFF);
					1:       push_raw(24'h800000);
					2:       push_raw(24'h000000);
					3:       push_raw(24'hFFFFFF);
					default: push_raw(24'h000001);
				endcase
				made++;
			end
		end
	endtask

	initial begin : stimulus
		logic [RAW_W-1:0] directed_a [16];
		logic [RAW_W-1:0] directed_b [4];
		logic [RAW_W-1:0] directed_c [5];
		int               window_kinds;

		arst_n         <= 1'b0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.index   <= '0;
		cfg_ch.data    <= '0;
		clear_filter_state();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: extremes pass straight through until the ring wraps,
		// a negative output forces a step, then plateaus shrink the window.
		directed_a = '{24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000000,
			24'h0003E8, 24'h0003E8, 24'h0003E8, 24'h0003F2, 24'h0003DE, 24'h0003E8,
			24'h004E20, 24'h004E20, 24'h004E20, 24'h004E20, 24'h004E20, 24'h000000};
		@(negedge clk);
		foreach (directed_a[i])
			push_raw(directed_a[i]);
		wait_drained();

		// Largest tare, minimum below range, maximum above the store, largest step.
		write_settings(24'h7FFFFF, 5'd0, 5'd31, 4'd15);
		directed_b = '{24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h000000};
		@(negedge clk);
		foreach (directed_b[i])
			push_raw(directed_b[i]);
		wait_drained();

		// Smallest tare, minimum above maximum, no growth on a step.
		write_settings(24'h800000, 5'd20, 5'd4, 4'd0);
		directed_c = '{24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h000000, 24'h7FFFFF};
		@(negedge clk);
		foreach (directed_c[i])
			push_raw(directed_c[i]);

		// Random phases, each under its own settings.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_drained();
			case (phase)
				0: write_settings(24'h000000, 5'd3, 5'd16, 4'd2);
				1: write_settings(RAW_W'($urandom), 5'd1, 5'd16, 4'd15);
				2: write_settings(RAW_W'($urandom), 5'd16, 5'd16, 4'd0);
				3: write_settings(RAW_W'($urandom), 5'd1, 5'd1, 4'd0);
				4: write_settings(RAW_W'($urandom), 5'd2, 5'd5, 4'd1);
				5: write_settings(RAW_W'($urandom), 5'd0, 5'd0, 4'd7);
				6: write_settings(RAW_W'($urandom), 5'(17 + $urandom_range(0, 14)),
					5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)));
				default: write_settings(RAW_W'($urandom), 5'($urandom), 5'($urandom),
					4'($urandom));
			endcase
			@(negedge clk);
			queue_stream(PHASE_ITEMS);
		end

		// Let the last results out, then watch for anything extra.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_filtered.size() != 0)
			report_mismatch($sformatf("%0d predicted results never arrived",
				awaited_filtered.size()));

		window_kinds = 0;
		foreach (windows_seen[i])
			window_kinds += windows_seen[i];
		$display("Summary: %0d samples in, %0d results checked, %0d register writes",
			beats_in, results_done, cfg_writes);
		$display("Summary: %0d distinct window lengths seen, %0d mismatches",
			window_kinds, mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
src/awmf_pkg.sv
src/awmf_if.sv
src/awmf_store.sv
src/awmf_select.sv
src/adaptive_window_median_filter_top.sv
dv/tb_adaptive_window_median_filter_top.sv
